// ----- hdl/cls_pkg.sv -----
`default_nettype none

package cls_pkg;

  // Field widths of the channels
  localparam int unsigned CharW     = 8;
  localparam int unsigned SensorW   = 10;
  localparam int unsigned CoilW     = 4;
  localparam int unsigned StepsOutW = 16;
  localparam int unsigned CodeWordW = 32;
  localparam int unsigned OpenStepsW = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_CODE_WORD          = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_OPEN_STEPS         = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_OBSTACLE_THRESHOLD = 2'd2;

  // Configuration reset values
  localparam logic [CodeWordW-1:0]  CODE_WORD_RST  = 32'h3333_3434;
  localparam logic [OpenStepsW-1:0] OPEN_STEPS_RST = 16'd900;
  localparam logic [SensorW-1:0]    THRESHOLD_RST  = 10'd1000;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_OPENING   = 2'd1,
    MODE_CLOSING   = 2'd2,
    MODE_REOPENING = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    VERDICT_NONE   = 2'd0,
    VERDICT_ACCEPT = 2'd1,
    VERDICT_REJECT = 2'd2
  } verdict_e;

  // Motor status handed from the drive logic to the result register
  typedef struct packed {
    logic [CoilW-1:0]     coils;
    mode_e                mode;
    logic [StepsOutW-1:0] steps;
  } motor_st_t;

  // Phase patterns: each phase sets one coil and clears another
  localparam logic [CoilW-1:0] FWD_SET [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
  localparam logic [CoilW-1:0] FWD_CLR [4] = '{4'h4, 4'h8, 4'h1, 4'h2};
  localparam logic [CoilW-1:0] REV_SET [4] = '{4'h8, 4'h4, 4'h2, 4'h1};
  localparam logic [CoilW-1:0] REV_CLR [4] = '{4'h2, 4'h1, 4'h8, 4'h4};

  function automatic logic [CoilW-1:0] coil_next(
    input logic [CoilW-1:0] coils,
    input logic             rev,
    input logic [1:0]       ph
  );
    logic [CoilW-1:0] res;
    if (rev) begin
      res = (coils | REV_SET[ph]) & ~REV_CLR[ph];
    end else begin
      res = (coils | FWD_SET[ph]) & ~FWD_CLR[ph];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/cls_if.sv -----
`default_nettype none

// Input item channel
interface cls_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [cls_pkg::CharW-1:0]   char_code;
  logic [cls_pkg::SensorW-1:0] sensor_level;

  modport source (output valid, output action, output char_code, output sensor_level,
                  input ready);
  modport sink   (input valid, input action, input char_code, input sensor_level,
                  output ready);
endinterface

// Result item channel
interface cls_out_if;
  logic                          valid;
  logic                          ready;
  logic [cls_pkg::CoilW-1:0]     coil_drive;
  logic [1:0]                    door_mode;
  logic [1:0]                    entered_count;
  logic [1:0]                    code_verdict;
  logic [cls_pkg::StepsOutW-1:0] steps_done;

  modport source (output valid, output coil_drive, output door_mode, output entered_count,
                  output code_verdict, output steps_done, input ready);
  modport sink   (input valid, input coil_drive, input door_mode, input entered_count,
                  input code_verdict, input steps_done, output ready);
endinterface

// Configuration write channel
interface cls_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cls_pkg::CfgIdxW-1:0]  index;
  logic [cls_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/code_lock_stepper_door_controller_unit.sv -----
`default_nettype none

// Channel  Modport  Handshake     Payload
// in_i     sink     valid/ready   action, char_code, sensor_level
// out_o    source   valid/ready   coil_drive, door_mode, entered_count, code_verdict,
//                                 steps_done
// cfg_i    sink     valid/ready   index, data (ready is always high)
//
// One item per cycle sustained while the result is not stalled; an accepted item
// passes through the input register, then the entry and motor update load it into
// the result register, from which its result can leave. Reset clears the entry
// index, door mode, phase, step counters and coils, and loads the configuration
// defaults. A stalled result holds the result register; the input register still
// takes one more item.

module code_lock_stepper_door_controller_unit #(
  parameter int unsigned CODE_LENGTH = 4,
  parameter int unsigned STEP_BITS   = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cls_in_if.sink    in_i,
  cls_out_if.source out_o,
  cls_cfg_if.sink   cfg_i
);
  import cls_pkg::*;

  // Configuration registers
  logic [CodeWordW-1:0]  code_word_q;
  logic [OpenStepsW-1:0] open_steps_q;
  logic [SensorW-1:0]    threshold_q;

  // Input register
  logic               in_valid_q;
  logic               in_action_q;
  logic [CharW-1:0]   in_char_q;
  logic [SensorW-1:0] in_sensor_q;

  // Result register
  logic                 out_valid_q;
  logic [CoilW-1:0]     out_coil_q;
  mode_e                out_mode_q;
  logic [1:0]           out_count_q;
  verdict_e             out_verdict_q;
  logic [StepsOutW-1:0] out_steps_q;

  logic      adv;
  logic      in_ready;
  logic      door_idle;
  logic      start_open;
  verdict_e  verdict;
  logic [1:0] count;
  motor_st_t motor_st;

  assign adv      = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || adv;
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_word_q  <= CODE_WORD_RST;
      open_steps_q <= OPEN_STEPS_RST;
      threshold_q  <= THRESHOLD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_CODE_WORD:          code_word_q  <= cfg_i.data;
        REG_OPEN_STEPS:         open_steps_q <= OpenStepsW'(cfg_i.data);
        REG_OBSTACLE_THRESHOLD: threshold_q  <= SensorW'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Hold the input item until it moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_ready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      in_action_q <= in_i.action;
      in_char_q   <= in_i.char_code;
      in_sensor_q <= in_i.sensor_level;
    end
  end

  cls_entry #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_entry (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_fire_i  (adv && !in_action_q),
    .door_idle_i  (door_idle),
    .char_code_i  (in_char_q),
    .code_word_i  (code_word_q),
    .verdict_o    (verdict),
    .count_o      (count),
    .start_open_o (start_open)
  );

  cls_motor #(
    .STEP_BITS (STEP_BITS)
  ) u_motor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (adv && in_action_q),
    .start_open_i (start_open),
    .sensor_i     (in_sensor_q),
    .open_steps_i (open_steps_q),
    .threshold_i  (threshold_q),
    .st_o         (motor_st),
    .idle_o       (door_idle)
  );

  // Load the result and drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_coil_q    <= motor_st.coils;
      out_mode_q    <= motor_st.mode;
      out_count_q   <= count;
      out_verdict_q <= verdict;
      out_steps_q   <= motor_st.steps;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.coil_drive    = out_coil_q;
  assign out_o.door_mode     = out_mode_q;
  assign out_o.entered_count = out_count_q;
  assign out_o.code_verdict  = out_verdict_q;
  assign out_o.steps_done    = out_steps_q;

`ifndef SYNTH
  // An accepted code always starts an opening travel
  a_accept_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_verdict_q == VERDICT_ACCEPT)) |-> (out_mode_q == MODE_OPENING))
    else $error("accepted code without opening");

  // A verdict always clears the entry
  a_verdict_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_verdict_q != VERDICT_NONE)) |-> (out_count_q == 2'd0))
    else $error("entry not cleared after verdict");

  // No characters are collected while the door moves
  a_moving_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_mode_q != MODE_IDLE)) |-> (out_count_q == 2'd0))
    else $error("characters collected while moving");

  // A stalled result keeps the input item waiting
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_o.ready) |=> in_valid_q)
    else $error("input item lost under stall");
`endif

endmodule

`default_nettype wire

// ----- hdl/cls_entry.sv -----
`default_nettype none

module cls_entry #(
  parameter int unsigned CODE_LENGTH = 4
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            char_fire_i,
  input  wire logic                            door_idle_i,
  input  wire logic [cls_pkg::CharW-1:0]       char_code_i,
  input  wire logic [cls_pkg::CodeWordW-1:0]   code_word_i,
  output cls_pkg::verdict_e                    verdict_o,
  output logic [1:0]                           count_o,
  output logic                                 start_open_o
);
  import cls_pkg::*;

  localparam int unsigned IdxW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CODE_LENGTH - 1);

  logic [IdxW-1:0]      idx_q, idx_d;
  logic [CharW-1:0]     buf_q [CODE_LENGTH];
  logic [CODE_LENGTH-1:0] hit;
  logic                 take;
  logic                 last;
  logic                 match;

  assign take = char_fire_i && door_idle_i;
  assign last = (idx_q == LastIdx);

  // Compare each position; the character at hand stands in for its own slot
  for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_cmp
    localparam int Shift = 8 * (CODE_LENGTH - 1 - i);
    logic [CharW-1:0] want;
    logic [CharW-1:0] got;
    if (Shift < 32) begin : g_in
      assign want = code_word_i[Shift +: 8];
    end else begin : g_out
      assign want = '0;
    end
    assign got    = (idx_q == IdxW'(i)) ? char_code_i : buf_q[i];
    assign hit[i] = (got == want);
  end

  assign match = &hit;

  // Advance the entry index and judge the code on the last character
  always_comb begin
    idx_d        = idx_q;
    verdict_o    = VERDICT_NONE;
    start_open_o = 1'b0;
    if (take) begin
      if (last) begin
        idx_d        = '0;
        verdict_o    = match ? VERDICT_ACCEPT : VERDICT_REJECT;
        start_open_o = match;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  assign count_o = 2'(idx_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Store the character; no reset needed since all slots fill before a compare
  always_ff @(posedge clk_i) begin
    if (take) begin
      buf_q[idx_q] <= char_code_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/cls_motor.sv -----
`default_nettype none

module cls_motor #(
  parameter int unsigned STEP_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           tick_i,
  input  wire logic                           start_open_i,
  input  wire logic [cls_pkg::SensorW-1:0]    sensor_i,
  input  wire logic [cls_pkg::OpenStepsW-1:0] open_steps_i,
  input  wire logic [cls_pkg::SensorW-1:0]    threshold_i,
  output cls_pkg::motor_st_t                  st_o,
  output logic                                idle_o
);
  import cls_pkg::*;

  localparam logic [STEP_BITS-1:0] StepMax = '1;

  mode_e                mode_q, mode_d;
  logic [1:0]           ph_q, ph_d;
  logic [STEP_BITS-1:0] sc_q, sc_d;
  logic [STEP_BITS-1:0] tg_q, tg_d;
  logic [CoilW-1:0]     coil_q, coil_d;

  logic [STEP_BITS-1:0] tmax;
  logic [STEP_BITS-1:0] sc_inc;
  logic                 obst;
  logic                 go;
  mode_e                mv_mode;

  // Saturate the travel length to the step counter width
  assign tmax = (32'(open_steps_i) > 32'(StepMax)) ? StepMax : STEP_BITS'(open_steps_i);
  assign obst = (sensor_i > threshold_i);
  assign sc_inc = sc_q + 1'b1;

  // Resolve travel ends and obstacles at a step start, then drive one phase
  always_comb begin
    mode_d  = mode_q;
    ph_d    = ph_q;
    sc_d    = sc_q;
    tg_d    = tg_q;
    coil_d  = coil_q;
    go      = 1'b0;
    mv_mode = mode_q;
    if (start_open_i) begin
      mode_d = MODE_OPENING;
      sc_d   = '0;
      tg_d   = tmax;
      ph_d   = '0;
    end else if (tick_i && (mode_q != MODE_IDLE)) begin
      go = 1'b1;
      if (ph_q == 2'd0) begin
        if (sc_q >= tg_q) begin
          if (mode_q == MODE_CLOSING) begin
            mode_d = MODE_IDLE;
            go     = 1'b0;
          end else begin
            mode_d  = MODE_CLOSING;
            mv_mode = MODE_CLOSING;
            sc_d    = '0;
            tg_d    = tmax;
            if (tmax == '0) begin
              mode_d = MODE_IDLE;
              go     = 1'b0;
            end else if (obst) begin
              go = 1'b0;
            end
          end
        end else if ((mode_q == MODE_CLOSING) && obst) begin
          if (sc_q == '0) begin
            go = 1'b0;
          end else begin
            tg_d    = sc_q;
            sc_d    = '0;
            mode_d  = MODE_REOPENING;
            mv_mode = MODE_REOPENING;
          end
        end
      end
      if (go) begin
        coil_d = coil_next(coil_q, mv_mode == MODE_CLOSING, ph_q);
        ph_d   = ph_q + 1'b1;
        // Count the full step after the fourth phase
        if (ph_q == 2'd3) begin
          sc_d = sc_inc;
          if (sc_inc >= tg_q) begin
            if (mv_mode == MODE_CLOSING) begin
              mode_d = MODE_IDLE;
            end else begin
              mode_d = MODE_CLOSING;
              sc_d   = '0;
              tg_d   = tmax;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      ph_q   <= '0;
      sc_q   <= '0;
      tg_q   <= '0;
      coil_q <= '0;
    end else begin
      mode_q <= mode_d;
      ph_q   <= ph_d;
      sc_q   <= sc_d;
      tg_q   <= tg_d;
      coil_q <= coil_d;
    end
  end

  assign st_o.coils = coil_d;
  assign st_o.mode  = mode_d;
  assign st_o.steps = StepsOutW'(sc_d);
  assign idle_o     = (mode_q == MODE_IDLE);

endmodule

`default_nettype wire
